// ===== design/received_pn_range_tracker_unit_defines.svh =====
// Assertion macros used by the range tracker unit.
`ifndef RECEIVED_PN_RANGE_TRACKER_UNIT_DEFINES_SVH
`define RECEIVED_PN_RANGE_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RPT_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RPT_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rpt_pkg.sv =====
// Types, codes and constants of the received packet number range tracker.
`default_nettype none

package rpt_pkg;

	localparam int MAX_RANGES = 32;
	localparam int PN_W       = 62;
	localparam int CNT_OUT_W  = 6;

	typedef logic [PN_W-1:0] pn_t;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_ERASE  = 2'd2,
		ACT_REPORT = 2'd3
	} action_t;

	typedef struct packed {
		action_t action;
		pn_t     pn;
	} in_item_t;

	typedef struct packed {
		logic                 present;
		pn_t                  range_low;
		pn_t                  range_high;
		pn_t                  gap;
		logic                 is_last;
		logic                 table_empty;
		logic                 overflow;
		logic [CNT_OUT_W-1:0] stored_ranges;
	} out_item_t;

	// Operation broadcast to every cell of the chain
	typedef enum logic [3:0] {
		OP_HOLD,
		OP_INS,
		OP_MERGE,
		OP_EXT_HI,
		OP_EXT_LO,
		OP_OVF,
		OP_SHIFT_DN,
		OP_CLAMP,
		OP_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		pn_t      pn;
	} cell_cmd_t;

	typedef struct packed {
		logic valid;
		pn_t  lo;
		pn_t  hi;
	} cell_data_t;

	// Compare results of one cell against the current packet number
	typedef struct packed {
		logic below;        // whole range lies under pn
		logic held;         // pn inside the range
		logic touch_top;    // hi + 1 == pn
		logic touch_bottom; // lo == pn + 1
	} cell_flags_t;

endpackage

`default_nettype wire

// ===== design/received_pn_range_tracker_unit.sv =====
// Received packet number range tracker: a chain of MAX_RANGES range cells
// kept sorted with the lowest range in cell 0. Add, query and erase items
// compare pn against every cell at once through registered compare flags.
// Add and query go through accept, compare, apply, then load of the result
// item into the output register once that register is free. Erase then
// shifts the chain down one cell per cycle, dropping one range each time,
// and clamps the head range. A report rotates the whole ring once through
// the top cell, pausing while the output register is busy, and emits the
// ranges highest first (an empty table gives one empty result). Only one
// item is in work at a time; a finished result waits in the output register
// while the next item is accepted.
`default_nettype none

`include "received_pn_range_tracker_unit_defines.svh"

module received_pn_range_tracker_unit #(
	parameter int MAX_RANGES = rpt_pkg::MAX_RANGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rpt_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output rpt_pkg::out_item_t out_item
);

	localparam int CNT_W  = $clog2(MAX_RANGES + 1);
	localparam int STEP_W = $clog2(MAX_RANGES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_APPLY,
		ST_ERASE,
		ST_REPORT,
		ST_FINISH
	} state_t;

	state_t               state_q;
	rpt_pkg::action_t     action_q;
	rpt_pkg::pn_t         pn_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     emitted_q;
	logic [STEP_W-1:0]    step_q;
	rpt_pkg::pn_t         prev_low_q;
	logic                 present_q;
	logic                 ovf_q;
	logic                 out_valid_q;
	rpt_pkg::out_item_t   out_q;

	rpt_pkg::cell_cmd_t   cmd;
	rpt_pkg::cell_data_t  cell_data  [MAX_RANGES];
	rpt_pkg::cell_flags_t cell_flags [MAX_RANGES];
	logic [MAX_RANGES-1:0] below_vec;
	logic [MAX_RANGES-1:0] valid_vec;
	logic [MAX_RANGES-1:0] held_vec;
	logic [MAX_RANGES-1:0] join_dn_vec;
	logic [MAX_RANGES-1:0] join_up_vec;

	logic                 held_any;
	logic                 join_dn;
	logic                 join_up;
	logic                 full;
	logic                 out_free;
	logic                 cnt_inc;
	logic                 cnt_dec;
	logic                 ovf_d;
	logic                 erase_done;
	logic                 emit;
	logic                 load_out;
	rpt_pkg::cell_data_t  tap;
	rpt_pkg::pn_t         gap_d;

	// Build the chain; cell 0 wraps to the top cell for rotation
	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		rpt_pkg::cell_data_t lower_n;
		rpt_pkg::cell_data_t upper_n;
		logic                below_p;
		logic                below_n;

		if (i == 0) begin : g_first
			assign lower_n = cell_data[MAX_RANGES-1];
			assign below_p = 1'b1;
		end else begin : g_mid_lo
			assign lower_n = cell_data[i-1];
			assign below_p = below_vec[i-1];
		end

		if (i == MAX_RANGES - 1) begin : g_last
			assign upper_n = '0;
			assign below_n = 1'b0;
		end else begin : g_mid_hi
			assign upper_n = cell_data[i+1];
			assign below_n = below_vec[i+1];
		end

		rpt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.head       (i == 0),
			.cmd        (cmd),
			.lower      (lower_n),
			.upper      (upper_n),
			.below_prev (below_p),
			.below_next (below_n),
			.data       (cell_data[i]),
			.flags      (cell_flags[i])
		);

		assign below_vec[i]   = cell_flags[i].below;
		assign valid_vec[i]   = cell_data[i].valid;
		assign held_vec[i]    = cell_flags[i].held;
		// pn extends the highest range under it, or lowers the first range over it
		assign join_dn_vec[i] = cell_flags[i].below && !below_n && cell_flags[i].touch_top;
		assign join_up_vec[i] = below_p && !cell_flags[i].below && cell_flags[i].touch_bottom;
	end

	assign held_any = |held_vec;
	assign join_dn  = |join_dn_vec;
	assign join_up  = |join_up_vec;
	assign full     = (count_q == CNT_W'(MAX_RANGES));
	assign out_free = !out_valid_q || out_ready;
	assign tap      = cell_data[MAX_RANGES-1];
	assign gap_d    = prev_low_q - tap.hi - rpt_pkg::PN_W'(2);
	assign load_out = emit || ((state_q == ST_FINISH) && out_free);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Decide the chain operation for this cycle
	always_comb begin
		cmd.op     = rpt_pkg::OP_HOLD;
		cmd.pn     = pn_q;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		ovf_d      = 1'b0;
		erase_done = 1'b0;
		emit       = 1'b0;
		unique case (state_q)
			ST_APPLY: begin
				if (action_q == rpt_pkg::ACT_ADD) begin
					priority if (held_any) begin
						cmd.op = rpt_pkg::OP_HOLD;
					end else if (join_dn && join_up) begin
						cmd.op  = rpt_pkg::OP_MERGE;
						cnt_dec = 1'b1;
					end else if (join_dn) begin
						cmd.op = rpt_pkg::OP_EXT_HI;
					end else if (join_up) begin
						cmd.op = rpt_pkg::OP_EXT_LO;
					end else if (full) begin
						ovf_d = 1'b1;
						if (below_vec[0]) begin
							cmd.op = rpt_pkg::OP_OVF;
						end
					end else begin
						cmd.op  = rpt_pkg::OP_INS;
						cnt_inc = 1'b1;
					end
				end
			end
			ST_ERASE: begin
				if (cell_data[0].valid && (pn_q >= cell_data[0].hi)) begin
					cmd.op  = rpt_pkg::OP_SHIFT_DN;
					cnt_dec = 1'b1;
				end else begin
					erase_done = 1'b1;
					if (cell_data[0].valid && (pn_q > cell_data[0].lo)) begin
						cmd.op = rpt_pkg::OP_CLAMP;
					end
				end
			end
			ST_REPORT: begin
				if ((count_q != '0) && (!tap.valid || out_free)) begin
					cmd.op = rpt_pkg::OP_ROT;
					emit   = tap.valid;
				end
			end
			default: begin
				cmd.op = rpt_pkg::OP_HOLD;
			end
		endcase
	end

	// Sequence items, track the range count and load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			action_q    <= rpt_pkg::ACT_ADD;
			pn_q        <= '0;
			count_q     <= '0;
			emitted_q   <= '0;
			step_q      <= '0;
			prev_low_q  <= '0;
			present_q   <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						action_q  <= in_item.action;
						pn_q      <= in_item.pn;
						present_q <= 1'b0;
						ovf_q     <= 1'b0;
						emitted_q <= '0;
						step_q    <= '0;
						if (in_item.action == rpt_pkg::ACT_REPORT) begin
							state_q <= ST_REPORT;
						end else begin
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					present_q <= (action_q == rpt_pkg::ACT_QUERY) && held_any;
					ovf_q     <= ovf_d;
					if (action_q == rpt_pkg::ACT_ERASE) begin
						state_q <= ST_ERASE;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_ERASE: begin
					if (erase_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_REPORT: begin
					if (count_q == '0) begin
						state_q <= ST_FINISH;
					end else if (cmd.op == rpt_pkg::OP_ROT) begin
						step_q <= step_q + STEP_W'(1);
						if (step_q == STEP_W'(MAX_RANGES - 1)) begin
							state_q <= ST_IDLE;
						end
						if (emit) begin
							out_q.present       <= 1'b0;
							out_q.range_low     <= tap.lo;
							out_q.range_high    <= tap.hi;
							out_q.gap           <= (emitted_q == '0) ? '0 : gap_d;
							out_q.is_last       <= ((emitted_q + CNT_W'(1)) == count_q);
							out_q.table_empty   <= 1'b0;
							out_q.overflow      <= 1'b0;
							out_q.stored_ranges <= rpt_pkg::CNT_OUT_W'(count_q);
							prev_low_q          <= tap.lo;
							emitted_q           <= emitted_q + CNT_W'(1);
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_q.present       <= present_q;
						out_q.range_low     <= '0;
						out_q.range_high    <= '0;
						out_q.gap           <= '0;
						out_q.is_last       <= 1'b1;
						out_q.table_empty   <= (count_q == '0);
						out_q.overflow      <= ovf_q;
						out_q.stored_ranges <= rpt_pkg::CNT_OUT_W'(count_q);
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The number of occupied cells matches the range count
	`RPT_CHECK(a_count_matches_cells, 1'b1, $countones(valid_vec) == count_q, "range count disagrees with occupied cells")

	// An accepted item always starts work
	`RPT_CHECK_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_q != ST_IDLE, "accepted item did not start")

	// The range count moves only while an add or an erase is applied
	`RPT_CHECK(a_count_moves_in_update, count_q != $past(count_q), $past(state_q) == ST_APPLY || $past(state_q) == ST_ERASE, "range count changed outside update")

	// A waiting result is never overwritten
	`RPT_CHECK_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_item), "pending result lost")

endmodule

`default_nettype wire

// ===== design/rpt_cell.sv =====
// One range cell: holds a range, compares it with pn, shifts with its neighbors.
`default_nettype none

module rpt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head,
	input  rpt_pkg::cell_cmd_t  cmd,
	input  rpt_pkg::cell_data_t lower,
	input  rpt_pkg::cell_data_t upper,
	input  logic                below_prev,
	input  logic                below_next,
	output rpt_pkg::cell_data_t data,
	output rpt_pkg::cell_flags_t flags
);

	localparam int XW = rpt_pkg::PN_W + 1;

	logic                 valid_q;
	rpt_pkg::pn_t         lo_q;
	rpt_pkg::pn_t         hi_q;
	rpt_pkg::cell_flags_t flags_q;
	rpt_pkg::cell_flags_t flags_d;
	rpt_pkg::cell_data_t  cur;
	rpt_pkg::cell_data_t  nxt;
	logic [XW-1:0]        pn_x;

	assign cur   = '{valid: valid_q, lo: lo_q, hi: hi_q};
	assign data  = cur;
	assign flags = flags_q;

	// Compare the stored range with the packet number
	always_comb begin
		pn_x = {1'b0, cmd.pn};
		flags_d.below        = valid_q && (hi_q < cmd.pn);
		flags_d.held         = valid_q && (lo_q <= cmd.pn) && (cmd.pn <= hi_q);
		flags_d.touch_top    = valid_q && (({1'b0, hi_q} + XW'(1)) == pn_x);
		flags_d.touch_bottom = valid_q && ({1'b0, lo_q} == (pn_x + XW'(1)));
	end

	// Pick the next content from this cell, a neighbor or the packet number
	always_comb begin
		nxt = cur;
		unique case (cmd.op)
			rpt_pkg::OP_HOLD: begin
				nxt = cur;
			end
			rpt_pkg::OP_INS: begin
				if (!below_prev) begin
					nxt = lower;
				end else if (!flags_q.below) begin
					nxt = '{valid: 1'b1, lo: cmd.pn, hi: cmd.pn};
				end
			end
			rpt_pkg::OP_MERGE: begin
				if (!flags_q.below) begin
					nxt = upper;
				end else if (!below_next) begin
					nxt.hi = upper.hi;
				end
			end
			rpt_pkg::OP_EXT_HI: begin
				if (flags_q.below && !below_next) begin
					nxt.hi = cmd.pn;
				end
			end
			rpt_pkg::OP_EXT_LO: begin
				if (below_prev && !flags_q.below) begin
					nxt.lo = cmd.pn;
				end
			end
			rpt_pkg::OP_OVF: begin
				if (below_next) begin
					nxt = upper;
				end else if (flags_q.below) begin
					nxt = '{valid: 1'b1, lo: cmd.pn, hi: cmd.pn};
				end
			end
			rpt_pkg::OP_SHIFT_DN: begin
				nxt = upper;
			end
			rpt_pkg::OP_CLAMP: begin
				if (head) begin
					nxt.lo = cmd.pn;
				end
			end
			rpt_pkg::OP_ROT: begin
				nxt = lower;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// Hold occupancy and compare flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flags_q <= '0;
		end else begin
			valid_q <= nxt.valid;
			flags_q <= flags_d;
		end
	end

	// Hold range bounds
	always_ff @(posedge clk) begin
		lo_q <= nxt.lo;
		hi_q <= nxt.hi;
	end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the received packet number range tracker.
`default_nettype none

module tb_top;

	localparam int           CELLS       = rpt_pkg::MAX_RANGES;
	localparam rpt_pkg::pn_t PN_MAX      = '1;
	localparam int           CYCLE_LIMIT = 2000000;
	localparam int           RAND_ITEMS  = 180;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	rpt_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	rpt_pkg::out_item_t out_item;

	// Mirror of the range table, lowest range in cell 0
	rpt_pkg::pn_t lo_tab [CELLS];
	rpt_pkg::pn_t hi_tab [CELLS];
	int           range_cnt;

	rpt_pkg::out_item_t due_results [$];

	int  mismatches;
	int  cycle_cnt;
	int  results_seen;
	int  overflow_seen;
	int  peak_ranges;
	int  action_cnt [4];
	bit  tx_steady;
	bit  rx_steady;
	int  rx_stall;

	received_pn_range_tracker_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	function automatic rpt_pkg::pn_t rand_pn();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[61:0];
	endfunction

	function automatic bit table_holds(rpt_pkg::pn_t pn);
		for (int i = 0; i < range_cnt; i++) begin
			if (pn >= lo_tab[i] && pn <= hi_tab[i]) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Join pn to the table; return 1 when a range had to be discarded
	function automatic bit add_number(rpt_pkg::pn_t pn);
		int above;
		bit join_lo;
		bit join_hi;
		if (table_holds(pn)) return 1'b0;
		above = 0;
		while (above < range_cnt && hi_tab[above] < pn) above++;
		join_lo = 1'b0;
		join_hi = 1'b0;
		if (above > 0) join_lo = ({2'b00, hi_tab[above-1]} + 64'd1) == {2'b00, pn};
		if (above < range_cnt) join_hi = {2'b00, lo_tab[above]} == ({2'b00, pn} + 64'd1);
		if (join_lo && join_hi) begin
			hi_tab[above-1] = hi_tab[above];
			for (int i = above; i + 1 < range_cnt; i++) begin
				lo_tab[i] = lo_tab[i+1];
				hi_tab[i] = hi_tab[i+1];
			end
			range_cnt--;
			return 1'b0;
		end
		if (join_lo) begin
			hi_tab[above-1] = pn;
			return 1'b0;
		end
		if (join_hi) begin
			lo_tab[above] = pn;
			return 1'b0;
		end
		// Full table: the lowest of the would-be set goes
		if (range_cnt >= CELLS) begin
			if (above == 0) return 1'b1;
			for (int i = 0; i + 1 < above; i++) begin
				lo_tab[i] = lo_tab[i+1];
				hi_tab[i] = hi_tab[i+1];
			end
			lo_tab[above-1] = pn;
			hi_tab[above-1] = pn;
			return 1'b1;
		end
		for (int i = range_cnt; i > above; i--) begin
			lo_tab[i] = lo_tab[i-1];
			hi_tab[i] = hi_tab[i-1];
		end
		lo_tab[above] = pn;
		hi_tab[above] = pn;
		range_cnt++;
		return 1'b0;
	endfunction

	function automatic void erase_below(rpt_pkg::pn_t pn);
		int drop;
		drop = 0;
		while (drop < range_cnt && pn >= hi_tab[drop]) drop++;
		for (int i = 0; i + drop < range_cnt; i++) begin
			lo_tab[i] = lo_tab[i+drop];
			hi_tab[i] = hi_tab[i+drop];
		end
		range_cnt -= drop;
		if (range_cnt > 0 && pn > lo_tab[0]) lo_tab[0] = pn;
	endfunction

	function automatic void push_result(logic present, rpt_pkg::pn_t lo, rpt_pkg::pn_t hi,
			rpt_pkg::pn_t gap, logic last, logic ovf);
		rpt_pkg::out_item_t r;
		r               = '0;
		r.present       = present;
		r.range_low     = lo;
		r.range_high    = hi;
		r.gap           = gap;
		r.is_last       = last;
		r.table_empty   = (range_cnt == 0);
		r.overflow      = ovf;
		r.stored_ranges = range_cnt[rpt_pkg::CNT_OUT_W-1:0];
		due_results.push_back(r);
	endfunction

	// Advance the mirror by one accepted item and queue the results it causes
	function automatic void step_ranges(rpt_pkg::in_item_t it);
		int           idx;
		bit           ovf;
		rpt_pkg::pn_t gap;
		action_cnt[it.action]++;
		case (it.action)
			rpt_pkg::ACT_ADD: begin
				ovf = add_number(it.pn);
				if (ovf) overflow_seen++;
				push_result(1'b0, '0, '0, '0, 1'b1, ovf);
			end
			rpt_pkg::ACT_QUERY: begin
				push_result(table_holds(it.pn), '0, '0, '0, 1'b1, 1'b0);
			end
			rpt_pkg::ACT_ERASE: begin
				erase_below(it.pn);
				push_result(1'b0, '0, '0, '0, 1'b1, 1'b0);
			end
			default: begin
				if (range_cnt == 0) begin
					push_result(1'b0, '0, '0, '0, 1'b1, 1'b0);
				end else begin
					for (int k = 0; k < range_cnt; k++) begin
						idx = range_cnt - 1 - k;
						gap = '0;
						if (k > 0) gap = lo_tab[idx+1] - hi_tab[idx] - rpt_pkg::pn_t'(2);
						push_result(1'b0, lo_tab[idx], hi_tab[idx], gap,
							k + 1 == range_cnt, 1'b0);
					end
				end
			end
		endcase
		if (range_cnt > peak_ranges) peak_ranges = range_cnt;
	endfunction

	// Present one item, hold it until accepted, then predict
	task automatic send_item(rpt_pkg::action_t act, rpt_pkg::pn_t pn);
		rpt_pkg::in_item_t it;
		int gap;
		it.action = act;
		it.pn     = pn;
		gap = tx_steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		step_ranges(it);
	endtask

	// Stop sending and wait until every queued result has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	// Result side: stall at random, with stretches of steady ready
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_steady) begin
			out_ready <= 1'b1;
		end else if (rx_stall > 0) begin
			out_ready <= 1'b0;
			rx_stall--;
		end else begin
			rx_stall = pick_gap();
			out_ready <= (rx_stall == 0);
			if (rx_stall > 0) rx_stall--;
		end
	end

	// Compare each delivered item with the oldest expectation
	always @(posedge clk) begin
		rpt_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: low %h high %h last %b count %0d",
						out_item.range_low, out_item.range_high, out_item.is_last,
						out_item.stored_ranges);
			end else begin
				want = due_results.pop_front();
				if (out_item.present !== want.present ||
						out_item.range_low !== want.range_low ||
						out_item.range_high !== want.range_high ||
						out_item.gap !== want.gap ||
						out_item.is_last !== want.is_last ||
						out_item.table_empty !== want.table_empty ||
						out_item.overflow !== want.overflow ||
						out_item.stored_ranges !== want.stored_ranges) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display({"mismatch exp: pres %b low %h high %h gap %h",
							" last %b empty %b ovf %b cnt %0d"},
							want.present, want.range_low, want.range_high, want.gap,
							want.is_last, want.table_empty, want.overflow,
							want.stored_ranges);
						$display({"         got: pres %b low %h high %h gap %h",
							" last %b empty %b ovf %b cnt %0d"},
							out_item.present, out_item.range_low, out_item.range_high,
							out_item.gap, out_item.is_last, out_item.table_empty,
							out_item.overflow, out_item.stored_ranges);
					end
				end
			end
		end
	end

	// Cycle watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Empty-table cases, every kind of join, duplicates, erase edges, reports
	task automatic test_directed();
		send_item(rpt_pkg::ACT_REPORT, rand_pn());
		send_item(rpt_pkg::ACT_QUERY, rpt_pkg::pn_t'(5));
		send_item(rpt_pkg::ACT_ERASE, rpt_pkg::pn_t'(7));
		send_item(rpt_pkg::ACT_ADD, '0);
		send_item(rpt_pkg::ACT_ADD, PN_MAX);
		send_item(rpt_pkg::ACT_ADD, PN_MAX - rpt_pkg::pn_t'(2));
		send_item(rpt_pkg::ACT_ADD, PN_MAX - rpt_pkg::pn_t'(1));
		send_item(rpt_pkg::ACT_ADD, rpt_pkg::pn_t'(10));
		send_item(rpt_pkg::ACT_ADD, rpt_pkg::pn_t'(11));
		send_item(rpt_pkg::ACT_ADD, rpt_pkg::pn_t'(9));
		send_item(rpt_pkg::ACT_ADD, rpt_pkg::pn_t'(10));
		send_item(rpt_pkg::ACT_QUERY, rpt_pkg::pn_t'(10));
		send_item(rpt_pkg::ACT_QUERY, rpt_pkg::pn_t'(12));
		send_item(rpt_pkg::ACT_QUERY, PN_MAX);
		send_item(rpt_pkg::ACT_REPORT, PN_MAX);
		send_item(rpt_pkg::ACT_ERASE, rpt_pkg::pn_t'(11));
		send_item(rpt_pkg::ACT_ADD, rpt_pkg::pn_t'(30));
		send_item(rpt_pkg::ACT_ADD, rpt_pkg::pn_t'(31));
		send_item(rpt_pkg::ACT_ADD, rpt_pkg::pn_t'(32));
		send_item(rpt_pkg::ACT_ERASE, rpt_pkg::pn_t'(31));
		send_item(rpt_pkg::ACT_QUERY, rpt_pkg::pn_t'(30));
		send_item(rpt_pkg::ACT_REPORT, '0);
		send_item(rpt_pkg::ACT_ERASE, PN_MAX);
		send_item(rpt_pkg::ACT_REPORT, rand_pn());
		send_item(rpt_pkg::ACT_QUERY, PN_MAX);
		drain();
	endtask

	// Fill the table, then force discards from both ends
	task automatic test_overflow();
		rpt_pkg::pn_t base;
		base = rand_pn();
		if (base > PN_MAX - rpt_pkg::pn_t'(4096)) base = base - rpt_pkg::pn_t'(4096);
		rx_steady = 1'b1;
		for (int k = 1; k <= CELLS; k++)
			send_item(rpt_pkg::ACT_ADD, base + rpt_pkg::pn_t'(2 * k));
		rx_steady = 1'b0;
		send_item(rpt_pkg::ACT_QUERY, base + rpt_pkg::pn_t'(2));
		send_item(rpt_pkg::ACT_ADD, base);
		send_item(rpt_pkg::ACT_QUERY, base);
		send_item(rpt_pkg::ACT_ADD, base + rpt_pkg::pn_t'(2 * (CELLS + 1)));
		send_item(rpt_pkg::ACT_ADD, base + rpt_pkg::pn_t'(21));
		send_item(rpt_pkg::ACT_ADD, base + rpt_pkg::pn_t'(1000));
		send_item(rpt_pkg::ACT_ADD, base + rpt_pkg::pn_t'(500));
		send_item(rpt_pkg::ACT_REPORT, base);
		send_item(rpt_pkg::ACT_ERASE, base + rpt_pkg::pn_t'(30));
		send_item(rpt_pkg::ACT_REPORT, base);
		send_item(rpt_pkg::ACT_ERASE, PN_MAX);
		drain();
	endtask

	// Windows of nearby numbers so ranges grow, join and overflow
	task automatic test_random();
		rpt_pkg::pn_t base;
		int           window;
		int           sent;
		int           burst;
		int           r;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			base = rand_pn();
			if (base > PN_MAX - rpt_pkg::pn_t'(4096)) base = base - rpt_pkg::pn_t'(4096);
			window    = $urandom_range(16, 90);
			burst     = $urandom_range(10, 40);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < burst; i++) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					send_item(rpt_pkg::ACT_ADD,
						base + rpt_pkg::pn_t'($urandom_range(0, window)));
				else if (r < 75)
					send_item(rpt_pkg::ACT_QUERY,
						base + rpt_pkg::pn_t'($urandom_range(0, window + 2)));
				else if (r < 82)
					send_item(rpt_pkg::ACT_ERASE,
						base + rpt_pkg::pn_t'($urandom_range(0, window / 3)));
				else if (r < 89)
					send_item(rpt_pkg::ACT_REPORT, rand_pn());
				else
					send_item(rpt_pkg::action_t'($urandom_range(0, 3)), rand_pn());
			end
			sent += burst;
			if ($urandom_range(0, 2) == 0) begin
				send_item(rpt_pkg::ACT_ERASE, ($urandom_range(0, 1) != 0) ? PN_MAX
					: base + rpt_pkg::pn_t'($urandom_range(0, window)));
				sent++;
			end
			if ($urandom_range(0, 3) == 0) drain();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_item       = '0;
		range_cnt     = 0;
		overflow_seen = 0;
		peak_ranges   = 0;
		tx_steady     = 1'b0;
		rx_steady     = 1'b0;
		for (int a = 0; a < 4; a++) action_cnt[a] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_overflow();
		test_random();

		// Let any trailing activity settle
		repeat (60) @(posedge clk);

		$display("items: %0d add, %0d query, %0d erase, %0d report; %0d results checked",
			action_cnt[rpt_pkg::ACT_ADD], action_cnt[rpt_pkg::ACT_QUERY],
			action_cnt[rpt_pkg::ACT_ERASE], action_cnt[rpt_pkg::ACT_REPORT], results_seen);
		$display("discards on full table: %0d, most ranges held: %0d, mismatches: %0d",
			overflow_seen, peak_ranges, mismatches);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
